/* src/rvs_pkg.sv */
// Shared types, widths and rail range tables for the voltage-to-selector block.
`timescale 1ns / 1ps

package rvs_pkg;

	localparam int RAILS       = 4;
	localparam int SEGS        = 4;
	localparam int RAIL_W      = 2;
	localparam int SEG_W       = 2;
	localparam int RAIL_IN_W   = 3;
	localparam int IN_MV_W     = 16;
	localparam int MV_W        = 12;
	localparam int SEL_W       = 7;
	localparam int STEP_W      = 7;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = MV_W + RECIP_W;

	// ceil(2^RECIP_SHIFT / step): exact floor division for every offset the tables allow
	localparam logic [RECIP_W-1:0] RECIP_10  = RECIP_W'(((1 << RECIP_SHIFT) + 9) / 10);
	localparam logic [RECIP_W-1:0] RECIP_20  = RECIP_W'(((1 << RECIP_SHIFT) + 19) / 20);
	localparam logic [RECIP_W-1:0] RECIP_25  = RECIP_W'(((1 << RECIP_SHIFT) + 24) / 25);
	localparam logic [RECIP_W-1:0] RECIP_40  = RECIP_W'(((1 << RECIP_SHIFT) + 39) / 40);
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);

	typedef struct packed {
		logic [MV_W-1:0]    base_mv;
		logic [MV_W-1:0]    top_mv;
		logic [SEL_W-1:0]   first_sel;
		logic [STEP_W-1:0]  step_mv;
		logic [RECIP_W-1:0] recip;
	} seg_t;

	// Chosen range and offset handed from range selection to the divider
	typedef struct packed {
		logic [MV_W-1:0]    off_mv;
		logic [SEL_W-1:0]   first_sel;
		logic [STEP_W-1:0]  step_mv;
		logic [RECIP_W-1:0] recip;
	} pick_t;

	function automatic seg_t make_seg(input int base, input int first, input int last,
			input int step, input logic [RECIP_W-1:0] recip);
		seg_t s;
		s.base_mv   = MV_W'(base);
		s.top_mv    = MV_W'(base + (last - first) * step);
		s.first_sel = SEL_W'(first);
		s.step_mv   = STEP_W'(step);
		s.recip     = recip;
		return s;
	endfunction

	localparam seg_t SEG_NONE = '0;

	localparam seg_t SEG_TBL [RAILS][SEGS] = '{
		'{make_seg(500, 'h00, 'h46, 10, RECIP_10), make_seg(1220, 'h47, 'h57, 20, RECIP_20),
		  make_seg(1800, 'h58, 'h67, 20, RECIP_20), make_seg(2440, 'h68, 'h70, 40, RECIP_40)},
		'{make_seg(500, 'h00, 'h46, 10, RECIP_10), make_seg(1220, 'h47, 'h57, 20, RECIP_20),
		  SEG_NONE, SEG_NONE},
		'{make_seg(500, 'h00, 'h46, 10, RECIP_10), make_seg(1220, 'h47, 'h57, 20, RECIP_20),
		  make_seg(1900, 'h58, 'h67, 100, RECIP_100), SEG_NONE},
		'{make_seg(500, 'h00, 'h28, 25, RECIP_25), SEG_NONE, SEG_NONE, SEG_NONE}
	};

	// Index of the last populated range of each rail
	localparam logic [SEG_W-1:0] LAST_SEG [RAILS] = '{2'd3, 2'd1, 2'd2, 2'd0};

endpackage

/* src/rvs_if.sv */
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps

interface rvs_req_if;
	logic                            valid;
	logic                            ready;
	logic [rvs_pkg::RAIL_IN_W-1:0]   rail;
	logic [rvs_pkg::IN_MV_W-1:0]     millivolts;

	modport source (output valid, output rail, output millivolts, input ready);
	modport sink (input valid, input rail, input millivolts, output ready);
endinterface

interface rvs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rvs_pkg::SEL_W-1:0]   selector;
	logic                        error;

	modport source (output valid, output selector, output error, input ready);
	modport sink (input valid, input selector, input error, output ready);
endinterface

/* src/rvs_range_sel.sv */
// Clamps the request to the rail and picks the first range whose top covers it.
`timescale 1ns / 1ps

module rvs_range_sel (
	input  logic [rvs_pkg::RAIL_W-1:0]  rail,
	input  logic [rvs_pkg::IN_MV_W-1:0] millivolts,
	output rvs_pkg::pick_t              pick
);

	logic [rvs_pkg::SEG_W-1:0]  last_idx;
	logic [rvs_pkg::MV_W-1:0]   lo_mv;
	logic [rvs_pkg::MV_W-1:0]   hi_mv;
	logic [rvs_pkg::MV_W-1:0]   mv_c;
	rvs_pkg::seg_t              seg;
	logic                       found;

	always_comb begin
		last_idx = rvs_pkg::LAST_SEG[rail];
		lo_mv    = rvs_pkg::SEG_TBL[rail][0].base_mv;
		hi_mv    = rvs_pkg::SEG_TBL[rail][last_idx].top_mv;
		priority if (millivolts < rvs_pkg::IN_MV_W'(lo_mv)) begin
			mv_c = lo_mv;
		end else if (millivolts > rvs_pkg::IN_MV_W'(hi_mv)) begin
			mv_c = hi_mv;
		end else begin
			mv_c = millivolts[rvs_pkg::MV_W-1:0];
		end
	end

	// First populated range whose top is at or above the clamped request
	always_comb begin
		seg   = rvs_pkg::SEG_TBL[rail][0];
		found = 1'b0;
		for (int i = 0; i < rvs_pkg::SEGS; i++) begin
			if (!found && (rvs_pkg::SEG_W'(i) <= last_idx)
					&& (mv_c <= rvs_pkg::SEG_TBL[rail][i].top_mv)) begin
				seg   = rvs_pkg::SEG_TBL[rail][i];
				found = 1'b1;
			end
		end
	end

	// At or below the base the offset is zero, which yields the first selector
	always_comb begin
		pick.off_mv    = (mv_c > seg.base_mv) ? mv_c - seg.base_mv : '0;
		pick.first_sel = seg.first_sel;
		pick.step_mv   = seg.step_mv;
		pick.recip     = seg.recip;
	end

endmodule

/* src/rvs_ceil_div.sv */
// Adds ceil(offset / step) to the range's first selector by reciprocal multiply.
`timescale 1ns / 1ps

module rvs_ceil_div (
	input  rvs_pkg::pick_t              pick,
	output logic [rvs_pkg::SEL_W-1:0]   selector
);

	logic [rvs_pkg::MV_W-1:0]   num;
	logic [rvs_pkg::PROD_W-1:0] prod;
	logic [rvs_pkg::SEL_W-1:0]  quot;

	always_comb begin
		num      = pick.off_mv + rvs_pkg::MV_W'(pick.step_mv) - rvs_pkg::MV_W'(1);
		prod     = rvs_pkg::PROD_W'(num) * rvs_pkg::PROD_W'(pick.recip);
		quot     = prod[rvs_pkg::RECIP_SHIFT +: rvs_pkg::SEL_W];
		selector = pick.first_sel + quot;
	end

endmodule

/* src/regulator_voltage_to_selector.sv */
// Regulator voltage-to-selector: rail and millivolts in, selector code and error out.
// An accepted request is captured in the input register, then loaded into the result register
// once that register is free; a stalled sink holds both stages.
// Throughput: one item per cycle while the sink keeps ready high; the range lookup, clamp and reciprocal multiply
// all sit in the single stage between the input register and the result register.
// Reset (arst_n low, asynchronous) empties both stages; there is no stored table state.
`timescale 1ns / 1ps

module regulator_voltage_to_selector (
	input  logic    clk,
	input  logic    arst_n,
	rvs_req_if.sink req,
	rvs_rsp_if.source rsp
);

	// Stage 1: captured request
	logic                            valid_s1;
	logic [rvs_pkg::RAIL_IN_W-1:0]   rail_s1;
	logic [rvs_pkg::IN_MV_W-1:0]     mv_s1;

	// Stage 2: result register
	logic                            valid_s2;
	logic [rvs_pkg::SEL_W-1:0]       sel_s2;
	logic                            err_s2;

	logic                            adv_s2;
	logic                            adv_s1;
	rvs_pkg::pick_t                  pick;
	logic [rvs_pkg::SEL_W-1:0]       sel_calc;
	logic                            bad_rail;

	// Result stage moves when empty or when the sink takes its item;
	// stage 1 takes a new item whenever its current item leaves or it is empty.
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req.valid;
		end
	end

	// Hold payload unless a new item is accepted
	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			rail_s1 <= req.rail;
			mv_s1   <= req.millivolts;
		end
	end

	// Rails past the last table entry are invalid
	assign bad_rail = rail_s1[rvs_pkg::RAIL_IN_W-1];

	rvs_range_sel u_range_sel (
		.rail       (rail_s1[rvs_pkg::RAIL_W-1:0]),
		.millivolts (mv_s1),
		.pick       (pick)
	);

	rvs_ceil_div u_ceil_div (
		.pick     (pick),
		.selector (sel_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Load the result; an invalid rail forces selector zero with the error flag
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			sel_s2 <= bad_rail ? '0 : sel_calc;
			err_s2 <= bad_rail;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.selector = sel_s2;
	assign rsp.error    = err_s2;

endmodule

/* verif/tb_regulator_voltage_to_selector.sv */
// Self-checking testbench for the regulator voltage-to-selector block.
`timescale 1ns / 1ps

module tb_regulator_voltage_to_selector;
	import rvs_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 6;
	localparam int PHASE_ITEMS    = 481;
	localparam int HOLDOFF_CYCLES = 120;
	localparam int DRAIN_CYCLES   = 8;
	localparam int QUIET_LIMIT    = 5000;
	localparam int DIRECTED_ROWS  = 25;

	// Rail range tables: base mV, first selector, last selector, step mV.
	// Unused slots carry a step of 1 so the top math stays harmless.
	localparam int RANGE_CNT [4]     = '{4, 2, 3, 1};
	localparam int RANGE_BASE [4][4] = '{'{500, 1220, 1800, 2440}, '{500, 1220, 0, 0},
		'{500, 1220, 1900, 0}, '{500, 0, 0, 0}};
	localparam int RANGE_FIRST [4][4] = '{'{'h00, 'h47, 'h58, 'h68}, '{'h00, 'h47, 0, 0},
		'{'h00, 'h47, 'h58, 0}, '{'h00, 0, 0, 0}};
	localparam int RANGE_LAST [4][4] = '{'{'h46, 'h57, 'h67, 'h70}, '{'h46, 'h57, 0, 0},
		'{'h46, 'h57, 'h67, 0}, '{'h28, 0, 0, 0}};
	localparam int RANGE_STEP [4][4] = '{'{10, 20, 20, 40}, '{10, 20, 1, 1},
		'{10, 20, 100, 1}, '{25, 1, 1, 1}};

	// Range edges of all rails, used to aim random requests at the corners
	localparam int BOUNDARY_MV [11] = '{500, 1200, 1220, 1540, 1800, 2100, 2440, 2760,
		1900, 3400, 1500};

	typedef struct packed {
		logic [SEL_W-1:0] selector;
		logic             error;
	} sel_result_t;

	typedef struct packed {
		bit [RAIL_IN_W-1:0] rail;
		bit [IN_MV_W-1:0]   mv;
		bit                 fixed;
		bit [SEL_W-1:0]     selector;
		bit                 error;
	} stim_row_t;

	typedef enum int {
		PH_STEADY,
		PH_SENDER_IDLE,
		PH_SINK_STALL,
		PH_BOTH_IDLE
	} idle_phase_t;

	// Directed requests. Rows with fixed set carry an expectation that can be read off
	// the tables directly; the rest go through the predictor.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{3'd0, 16'd0,     1'b1, 7'h00, 1'b0},	// below rail minimum clamps to first selector
		'{3'd0, 16'd65535, 1'b1, 7'h70, 1'b0},	// above rail maximum clamps to last selector
		'{3'd1, 16'd0,     1'b1, 7'h00, 1'b0},
		'{3'd1, 16'd65535, 1'b1, 7'h57, 1'b0},
		'{3'd2, 16'd0,     1'b1, 7'h00, 1'b0},
		'{3'd2, 16'd65535, 1'b1, 7'h67, 1'b0},
		'{3'd3, 16'd0,     1'b1, 7'h00, 1'b0},
		'{3'd3, 16'd65535, 1'b1, 7'h28, 1'b0},
		'{3'd4, 16'd1234,  1'b1, 7'h00, 1'b1},	// invalid rails flag an error
		'{3'd5, 16'd0,     1'b1, 7'h00, 1'b1},
		'{3'd6, 16'd65535, 1'b1, 7'h00, 1'b1},
		'{3'd7, 16'd2000,  1'b1, 7'h00, 1'b1},
		'{3'd0, 16'd1210,  1'b1, 7'h47, 1'b0},	// gap between ranges takes next first selector
		'{3'd2, 16'd1700,  1'b1, 7'h58, 1'b0},
		'{3'd0, 16'd1200,  1'b0, 7'h00, 1'b0},
		'{3'd0, 16'd1221,  1'b0, 7'h00, 1'b0},
		'{3'd0, 16'd1541,  1'b0, 7'h00, 1'b0},
		'{3'd0, 16'd2100,  1'b0, 7'h00, 1'b0},
		'{3'd0, 16'd2300,  1'b0, 7'h00, 1'b0},
		'{3'd0, 16'd2441,  1'b0, 7'h00, 1'b0},
		'{3'd1, 16'd1539,  1'b0, 7'h00, 1'b0},
		'{3'd2, 16'd1901,  1'b0, 7'h00, 1'b0},
		'{3'd2, 16'd3399,  1'b0, 7'h00, 1'b0},
		'{3'd3, 16'd501,   1'b0, 7'h00, 1'b0},
		'{3'd3, 16'd1499,  1'b0, 7'h00, 1'b0}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rvs_req_if req_ch ();
	rvs_rsp_if rsp_ch ();

	regulator_voltage_to_selector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Results still owed by the block, oldest first
	sel_result_t pending_selectors [$];

	int failures       = 0;
	int quiet_cycles   = 0;
	int idle_pct       = 0;	// chance in percent that the sender skips a cycle
	int stall_pct      = 0;	// chance in percent that the receiver drops ready
	int holdoff_ticket = 0;	// bumped by the stimulus to ask for a long receiver hold-off
	int holdoff_served = 0;
	int holdoff_left   = 0;

	always #HALF_PERIOD clk = ~clk;

	// Compute the selector code for one request: clamp to the rail, pick the first
	// range whose top covers the request, then round the offset up to the next step.
	function automatic sel_result_t predict_selector(input logic [RAIL_IN_W-1:0] rail,
			input logic [IN_MV_W-1:0] mv);
		sel_result_t res;
		int r, v, last, lo, hi, top, sel;
		bit found;
		res   = '0;
		sel   = 0;
		found = 1'b0;
		if (rail >= RAIL_IN_W'(RAILS)) begin
			res.error = 1'b1;
		end else begin
			r    = int'(rail);
			v    = int'(mv);
			last = RANGE_CNT[r] - 1;
			lo   = RANGE_BASE[r][0];
			hi   = RANGE_BASE[r][last]
				+ (RANGE_LAST[r][last] - RANGE_FIRST[r][last]) * RANGE_STEP[r][last];
			if (v < lo) begin
				v = lo;
			end
			if (v > hi) begin
				v = hi;
			end
			for (int i = 0; i < RANGE_CNT[r]; i++) begin
				top = RANGE_BASE[r][i] + (RANGE_LAST[r][i] - RANGE_FIRST[r][i]) * RANGE_STEP[r][i];
				if (!found && v <= top) begin
					if (v <= RANGE_BASE[r][i]) begin
						sel = RANGE_FIRST[r][i];
					end else begin
						sel = RANGE_FIRST[r][i]
							+ (v - RANGE_BASE[r][i] + RANGE_STEP[r][i] - 1) / RANGE_STEP[r][i];
					end
					found = 1'b1;
				end
			end
			res.selector = SEL_W'(sel);
		end
		return res;
	endfunction

	// Mostly land near the live voltage window and on the range edges, with a share
	// of full-width values so every input bit toggles.
	function automatic logic [IN_MV_W-1:0] random_millivolts();
		int pick;
		int mv;
		pick = $urandom_range(99);
		if (pick < 40) begin
			mv = $urandom_range(3600, 400);
		end else if (pick < 70) begin
			mv = BOUNDARY_MV[$urandom_range(10)] + $urandom_range(6) - 3;
		end else if (pick < 85) begin
			mv = $urandom_range(65535);
		end else if (pick < 93) begin
			mv = $urandom_range(499);
		end else begin
			mv = $urandom_range(65535, 60000);
		end
		return IN_MV_W'(mv);
	endfunction

	// Offer one request, idling first at the current rate. Valid stays high from the
	// previous item when no idle cycle is drawn. Record the expectation on acceptance.
	task automatic send_request(input logic [RAIL_IN_W-1:0] rail, input logic [IN_MV_W-1:0] mv,
			input bit use_fixed, input sel_result_t fixed_result);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.rail       <= rail;
		req_ch.millivolts <= mv;
		do @(posedge clk); while (!req_ch.ready);
		if (use_fixed) begin
			pending_selectors.push_back(fixed_result);
		end else begin
			pending_selectors.push_back(predict_selector(rail, mv));
		end
	endtask

	// Drop valid and hold the sender until the block has returned every result.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_selectors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver: a requested hold-off takes priority and is counted down here;
	// otherwise ready follows the stall rate of the current phase.
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			rsp_ch.ready <= 1'b0;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_ticket != holdoff_served) begin
			rsp_ch.ready   <= 1'b0;
			holdoff_served <= holdoff_ticket;
			holdoff_left   <= HOLDOFF_CYCLES;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each accepted result with the oldest expectation; track quiet cycles.
	always @(posedge clk) begin : check_results
		sel_result_t want;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_selectors.size() == 0) begin
				$error("unexpected result: selector %0d, error %0d", rsp_ch.selector, rsp_ch.error);
				failures++;
			end else begin
				want = pending_selectors.pop_front();
				if (rsp_ch.selector !== want.selector) begin
					$error("selector mismatch: expected %0d, actual %0d", want.selector,
						rsp_ch.selector);
					failures++;
				end
				if (rsp_ch.error !== want.error) begin
					$error("error mismatch: expected %0d, actual %0d", want.error, rsp_ch.error);
					failures++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Main stimulus: reset, directed table, then random phases under varied idling.
	initial begin
		logic [RAIL_IN_W-1:0] rail;
		sel_result_t          fixed_result;
		idle_phase_t          phase;

		req_ch.valid      = 1'b0;
		req_ch.rail       = '0;
		req_ch.millivolts = '0;

		// Hold reset, then release on a clock edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table back to back
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			fixed_result.selector = DIRECTED[i].selector;
			fixed_result.error    = DIRECTED[i].error;
			send_request(DIRECTED[i].rail, DIRECTED[i].mv, DIRECTED[i].fixed, fixed_result);
		end
		drain_results();

		// Random part, one phase per idling pattern; each phase ends with the sender
		// pausing until every result is back
		for (int p = 0; p <= int'(PH_BOTH_IDLE); p++) begin
			phase = idle_phase_t'(p);
			case (phase)
				PH_STEADY: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				PH_SENDER_IDLE: begin
					idle_pct  = 84;
					stall_pct = 0;
				end
				PH_SINK_STALL: begin
					idle_pct  = 0;
					stall_pct = 84;
				end
				default: begin
					idle_pct  = 34;
					stall_pct = 34;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Early in the steady phase, freeze the receiver while requests keep
				// coming, so the pipeline fills and back-pressures the input
				if (phase == PH_STEADY && n == 20) begin
					holdoff_ticket++;
				end
				if ($urandom_range(99) < 12) begin
					rail = RAIL_IN_W'($urandom_range(7, 4));
				end else begin
					rail = RAIL_IN_W'($urandom_range(3, 0));
				end
				send_request(rail, random_millivolts(), 1'b0, '0);
			end
			drain_results();
		end

		// Let any stray output show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_selectors.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
